>>> design/lrts_pkg.sv
// Types and constants for the letter-run token segmenter.
// Shared by the channel interfaces, the run units, the token queue and the top level.
`default_nettype none

package lrts_pkg;

	localparam int START_W = 16;
	localparam int END_W   = 17;
	localparam int CNT_W   = 17;

	typedef enum logic [1:0] {
		CLS_OTHER  = 2'd0,
		CLS_LETTER = 2'd1,
		CLS_DIGIT  = 2'd2,
		CLS_PUNCT  = 2'd3
	} char_class_t;

	typedef enum logic [1:0] {
		KIND_ENG = 2'd0,
		KIND_DIG = 2'd1,
		KIND_MIX = 2'd2
	} token_kind_t;

	typedef struct packed {
		logic [1:0]         char_class;
		logic               num_connector_flag;
		logic               letter_connector_flag;
		logic [START_W-1:0] char_start;
		logic [END_W-1:0]   char_end;
		logic               text_last;
	} char_t;

	typedef struct packed {
		logic               act;
		logic [START_W-1:0] beg;
		logic [END_W-1:0]   fin;
		logic [CNT_W-1:0]   chars;
		logic [CNT_W-1:0]   pend;
	} run_t;

	typedef struct packed {
		logic start;
		logic body;
		logic conn;
		logic last;
	} unit_ctl_t;

	typedef struct packed {
		token_kind_t        kind;
		logic [START_W-1:0] start;
		logic [END_W-1:0]   length;
		logic [CNT_W-1:0]   count;
	} token_t;

endpackage

`default_nettype wire

>>> design/lrts_char_if.sv
// Request channel carrying one classified character.
// Depends on lrts_pkg for field widths.
`default_nettype none

interface lrts_char_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  char_class;
	logic                        num_connector_flag;
	logic                        letter_connector_flag;
	logic [lrts_pkg::START_W-1:0] char_start;
	logic [lrts_pkg::END_W-1:0]   char_end;
	logic                        text_last;

	modport source (
		output valid, char_class, num_connector_flag, letter_connector_flag,
		       char_start, char_end, text_last,
		input  ready
	);
	modport sink (
		input  valid, char_class, num_connector_flag, letter_connector_flag,
		       char_start, char_end, text_last,
		output ready
	);
endinterface

`default_nettype wire

>>> design/lrts_token_if.sv
// Request channel carrying one emitted token.
// Depends on lrts_pkg for field widths.
`default_nettype none

interface lrts_token_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  token_kind;
	logic [lrts_pkg::START_W-1:0] token_start;
	logic [lrts_pkg::END_W-1:0]   token_length;
	logic [lrts_pkg::CNT_W-1:0]   char_count;
	logic                        run_last;

	modport source (
		output valid, token_kind, token_start, token_length, char_count, run_last,
		input  ready
	);
	modport sink (
		input  valid, token_kind, token_start, token_length, char_count, run_last,
		output ready
	);
endinterface

`default_nettype wire

>>> design/lrts_run_unit.sv
// One run segmenter: run state register and its combinational update.
// Emits at most one token per character. Depends on lrts_pkg.
`default_nettype none

module lrts_run_unit #(
	parameter int unsigned MAX_TEXT_BYTES = 65536
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire lrts_pkg::unit_ctl_t          ctl,
	input  wire logic [lrts_pkg::START_W-1:0] char_start,
	input  wire logic [lrts_pkg::END_W-1:0]   char_end,
	output logic                              emit,
	output logic [lrts_pkg::START_W-1:0]      tok_start,
	output logic [lrts_pkg::END_W-1:0]        tok_length,
	output logic [lrts_pkg::CNT_W-1:0]        tok_count
);

	localparam logic [lrts_pkg::CNT_W:0] CntCap =
		(MAX_TEXT_BYTES < 32'h1FFFF) ? (lrts_pkg::CNT_W+1)'(MAX_TEXT_BYTES) :
		                               (lrts_pkg::CNT_W+1)'(32'h1FFFF);

	lrts_pkg::run_t run_q;
	lrts_pkg::run_t run_nxt;
	lrts_pkg::run_t tok_src;
	logic [lrts_pkg::CNT_W:0] chars_sum;
	logic [lrts_pkg::CNT_W:0] pend_sum;

	assign chars_sum = {1'b0, run_q.chars} + {1'b0, run_q.pend} + (lrts_pkg::CNT_W+1)'(1);
	assign pend_sum  = {1'b0, run_q.pend} + (lrts_pkg::CNT_W+1)'(1);

	always_comb begin
		run_nxt = run_q;
		tok_src = run_q;
		emit    = 1'b0;
		if (!run_q.act) begin
			if (ctl.start) begin
				run_nxt.act   = 1'b1;
				run_nxt.beg   = char_start;
				run_nxt.fin   = char_end;
				run_nxt.chars = lrts_pkg::CNT_W'(1);
				run_nxt.pend  = '0;
			end
		end else if (ctl.body) begin
			run_nxt.fin   = char_end;
			run_nxt.chars = (chars_sum > CntCap) ? CntCap[lrts_pkg::CNT_W-1:0]
			                                     : chars_sum[lrts_pkg::CNT_W-1:0];
			run_nxt.pend  = '0;
		end else if (ctl.conn) begin
			run_nxt.pend = (pend_sum > CntCap) ? CntCap[lrts_pkg::CNT_W-1:0]
			                                   : pend_sum[lrts_pkg::CNT_W-1:0];
		end else begin
			emit    = 1'b1;
			run_nxt = '0;
		end
		if (ctl.last && run_nxt.act) begin
			emit    = 1'b1;
			tok_src = run_nxt;
			run_nxt = '0;
		end
	end

	assign tok_start  = tok_src.beg;
	assign tok_length = lrts_pkg::END_W'(tok_src.fin - {1'b0, tok_src.beg});
	assign tok_count  = tok_src.chars;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (advance) begin
			run_q <= run_nxt;
		end
	end

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> !run_q.act)
		else $error("run still active after emitting its token");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q.act |-> (run_q.chars == '0 && run_q.pend == '0))
		else $error("idle run holds counts");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> (tok_count != '0))
		else $error("token emitted with zero characters");

endmodule

`default_nettype wire

>>> design/lrts_tok_queue.sv
// Result register for a character's up to three tokens, drained one per cycle while ready.
// Depends on lrts_pkg and lrts_token_if.
`default_nettype none

module lrts_tok_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic [2:0]            load_mask,
	input  wire lrts_pkg::token_t [2:0] load_tok,
	output logic                       free,
	lrts_token_if.source               tokens
);

	lrts_pkg::token_t [2:0] tok_q;
	logic [2:0]             valid_q;
	logic [1:0]             sel;
	logic [2:0]             take_mask;
	logic                   take;

	always_comb begin
		if (valid_q[0]) begin
			sel = 2'd0;
		end else if (valid_q[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	assign take      = tokens.valid && tokens.ready;
	assign take_mask = take ? (3'b001 << sel) : 3'b000;
	assign free      = (valid_q & ~take_mask) == 3'b000;

	assign tokens.valid        = valid_q != 3'b000;
	assign tokens.token_kind   = tok_q[sel].kind;
	assign tokens.token_start  = tok_q[sel].start;
	assign tokens.token_length = tok_q[sel].length;
	assign tokens.char_count   = tok_q[sel].count;

	always_comb begin
		case (sel)
			2'd0:    tokens.run_last = !valid_q[1] && !valid_q[2];
			2'd1:    tokens.run_last = !valid_q[2];
			default: tokens.run_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (load) begin
			valid_q <= load_mask;
		end else begin
			valid_q <= valid_q & ~take_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= load_tok;
		end
	end

	a_drain_one: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !load) |=> ($countones(valid_q) == $past($countones(valid_q)) - 1))
		else $error("drain removed other than one token");

	a_group_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !tokens.run_last) |=> (tokens.valid && !$past(load)))
		else $error("tokens of one character not delivered together");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("queue overwritten before drained");

endmodule

`default_nettype wire

>>> design/letter_run_token_segmenter.sv
// Letter-run token segmenter top level: input register, three run units, token queue.
// Depends on lrts_pkg, lrts_char_if, lrts_token_if, lrts_run_unit, lrts_tok_queue.
//
// Usage:
//   chars  : one classified character per request (class, connector flags, byte
//            start and end, last-of-text). Accepted when valid and ready are high.
//   tokens : emitted tokens (kind, start, byte length, character count, run_last),
//            in the order English, digit, mixed; run_last marks the final token
//            caused by one character.
//   Flow: a character registers in the input register on acceptance; its tokens
//   load into the token register once that is free and are presented from there.
//   Throughput: one character per cycle while tokens.ready is high and each
//   character ends at most one run. A character that ends k runs holds the token
//   register until its k tokens drain, since the token port delivers one token per
//   cycle; the next character waits in the input register meanwhile.
//   Reset: all runs become idle and both registers empty.
//   Stall: when tokens.ready is low the token register holds; the input register
//   takes one more character, then chars.ready drops until tokens drain.
`default_nettype none

module letter_run_token_segmenter #(
	parameter int unsigned MAX_TEXT_BYTES = 65536
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lrts_char_if.sink   chars,
	lrts_token_if.source tokens
);

	lrts_pkg::char_t        char_s1;
	logic                   valid_s1;
	logic                   process;
	logic                   q_free;
	logic                   punct;
	lrts_pkg::unit_ctl_t    ctl_eng;
	lrts_pkg::unit_ctl_t    ctl_dig;
	lrts_pkg::unit_ctl_t    ctl_mix;
	logic [2:0]             emit;
	logic [lrts_pkg::START_W-1:0] t_start [3];
	logic [lrts_pkg::END_W-1:0]   t_len   [3];
	logic [lrts_pkg::CNT_W-1:0]   t_cnt   [3];
	lrts_pkg::token_t [2:0] load_tok;

	assign process     = valid_s1 && q_free;
	assign chars.ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1.char_class            <= chars.char_class;
			char_s1.num_connector_flag    <= chars.num_connector_flag;
			char_s1.letter_connector_flag <= chars.letter_connector_flag;
			char_s1.char_start            <= chars.char_start;
			char_s1.char_end              <= chars.char_end;
			char_s1.text_last             <= chars.text_last;
		end
	end

	assign punct = char_s1.char_class == lrts_pkg::CLS_PUNCT;

	always_comb begin
		ctl_eng.start = char_s1.char_class == lrts_pkg::CLS_LETTER;
		ctl_eng.body  = ctl_eng.start;
		ctl_eng.conn  = 1'b0;
		ctl_eng.last  = char_s1.text_last;

		ctl_dig.start = char_s1.char_class == lrts_pkg::CLS_DIGIT;
		ctl_dig.body  = ctl_dig.start;
		ctl_dig.conn  = punct && char_s1.num_connector_flag;
		ctl_dig.last  = char_s1.text_last;

		ctl_mix.start = ctl_eng.start || ctl_dig.start;
		ctl_mix.body  = ctl_mix.start || (punct && char_s1.letter_connector_flag);
		ctl_mix.conn  = 1'b0;
		ctl_mix.last  = char_s1.text_last;
	end

	lrts_run_unit #(.MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_eng (
		.clk, .arst_n, .advance(process), .ctl(ctl_eng),
		.char_start(char_s1.char_start), .char_end(char_s1.char_end),
		.emit(emit[0]), .tok_start(t_start[0]), .tok_length(t_len[0]), .tok_count(t_cnt[0])
	);

	lrts_run_unit #(.MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_dig (
		.clk, .arst_n, .advance(process), .ctl(ctl_dig),
		.char_start(char_s1.char_start), .char_end(char_s1.char_end),
		.emit(emit[1]), .tok_start(t_start[1]), .tok_length(t_len[1]), .tok_count(t_cnt[1])
	);

	lrts_run_unit #(.MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_mix (
		.clk, .arst_n, .advance(process), .ctl(ctl_mix),
		.char_start(char_s1.char_start), .char_end(char_s1.char_end),
		.emit(emit[2]), .tok_start(t_start[2]), .tok_length(t_len[2]), .tok_count(t_cnt[2])
	);

	always_comb begin
		load_tok[0] = '{kind: lrts_pkg::KIND_ENG, start: t_start[0], length: t_len[0],
		                count: t_cnt[0]};
		load_tok[1] = '{kind: lrts_pkg::KIND_DIG, start: t_start[1], length: t_len[1],
		                count: t_cnt[1]};
		load_tok[2] = '{kind: lrts_pkg::KIND_MIX, start: t_start[2], length: t_len[2],
		                count: t_cnt[2]};
	end

	lrts_tok_queue u_queue (
		.clk, .arst_n,
		.load(process), .load_mask(emit), .load_tok(load_tok),
		.free(q_free), .tokens(tokens)
	);

endmodule

`default_nettype wire
